### rtl/core/kmer_bottom_k_sketch_defines.svh
// ----------------------------------------------------------------------------
// kmer bottom-k sketch assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef KMER_BOTTOM_K_SKETCH_DEFINES_SVH
`define KMER_BOTTOM_K_SKETCH_DEFINES_SVH

`ifndef SYNTH
`define KBKS_CHECK(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("kbks check failed");
`define KBKS_CHECK_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kbks check failed");
`define KBKS_CHECK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kbks check failed");
`else
`define KBKS_CHECK(lbl, clk, rstn, expr)
`define KBKS_CHECK_IMPL(lbl, clk, rstn, ante, cons)
`define KBKS_CHECK_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/core/kbks_pkg.sv
// ----------------------------------------------------------------------------
// kbks_pkg
// shared types, codes and constants of the k-mer bottom-k sketch
// ----------------------------------------------------------------------------
package kbks_pkg;

    localparam logic [1:0] ACT_BASE  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic REG_KMER_SIZE   = 1'b0;
    localparam logic REG_SKETCH_SIZE = 1'b1;

    localparam logic [4:0] KMER_SIZE_RESET   = 5'd21;
    localparam logic [7:0] SKETCH_SIZE_RESET = 8'd128;

    localparam logic [63:0] MASK62 = 64'h3FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] base_byte;
        logic [6:0] entry_index;
    } t_in_word;

    typedef struct packed {
        logic [63:0] hash_value;
        logic        hash_valid;
        logic        inserted;
        logic [7:0]  sketch_count;
    } t_out_word;

    typedef struct packed {
        logic       load;
        logic       hash_en;
        logic [1:0] hash_step;
        logic       cmp_en;
        logic       upd_en;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic fresh;
    } t_dp_status;

    // 2-bit base code, bit 2 set for a non-nucleotide byte
    function automatic logic [2:0] base_code(input logic [7:0] b);
        logic [2:0] c;
        case (b)
            8'h41, 8'h61: c = 3'd0;
            8'h43, 8'h63: c = 3'd1;
            8'h47, 8'h67: c = 3'd2;
            8'h54, 8'h74: c = 3'd3;
            default:      c = 3'd4;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/kbks_ctrl.sv
// ----------------------------------------------------------------------------
// kbks_ctrl
// sequencer for one word: decode, hash rounds, compare, update, result
// ----------------------------------------------------------------------------
`include "kmer_bottom_k_sketch_defines.svh"

module kbks_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  kbks_pkg::t_dp_status i_status,
    output kbks_pkg::t_dp_cmd    o_cmd
);
    import kbks_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_H0, S_H1, S_H2, S_H3, S_CMP, S_UPD
    } t_state;

    t_state r_state, n_state;
    logic   r_res_pend, n_res_pend;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_in_valid && (r_state == S_IDLE) && !r_res_pend;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = accept;
        o_cmd.hash_step = 2'd0;
        case (r_state)
            S_H0: begin
                o_cmd.hash_en   = 1'b1;
                o_cmd.hash_step = 2'd0;
            end
            S_H1: begin
                o_cmd.hash_en   = 1'b1;
                o_cmd.hash_step = 2'd1;
            end
            S_H2: begin
                o_cmd.hash_en   = 1'b1;
                o_cmd.hash_step = 2'd2;
            end
            S_H3: begin
                o_cmd.hash_en   = 1'b1;
                o_cmd.hash_step = 2'd3;
            end
            S_CMP:   o_cmd.cmp_en = 1'b1;
            S_UPD:   o_cmd.upd_en = 1'b1;
            default: o_cmd.cmp_en = 1'b0;
        endcase
        o_cmd.out_load = r_res_pend && out_free;
    end

    always_comb begin
        n_state     = r_state;
        n_res_pend  = r_res_pend;
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_res_pend  = 1'b0;
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.fresh) begin
                    n_state = S_H0;
                end else begin
                    n_state    = S_IDLE;
                    n_res_pend = 1'b1;
                end
            end
            S_H0:  n_state = S_H1;
            S_H1:  n_state = S_H2;
            S_H2:  n_state = S_H3;
            S_H3:  n_state = S_CMP;
            S_CMP: n_state = S_UPD;
            S_UPD: begin
                n_state    = S_IDLE;
                n_res_pend = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_pend  <= n_res_pend;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE) || r_res_pend;
    assign o_out_valid = r_out_valid;

    `KBKS_CHECK_NEXT(a_accept_decides, i_clk, i_rst_n, accept, r_state == S_DECIDE)
    `KBKS_CHECK_IMPL(a_upd_after_cmp, i_clk, i_rst_n, o_cmd.upd_en, $past(o_cmd.cmp_en))
    `KBKS_CHECK_IMPL(a_out_from_pend, i_clk, i_rst_n, $rose(o_out_valid), $past(r_res_pend))

endmodule

### rtl/core/kbks_dp.sv
// ----------------------------------------------------------------------------
// kbks_dp
// rolling k-mers, staged hash, sorted sketch cells and result register
// ----------------------------------------------------------------------------
`include "kmer_bottom_k_sketch_defines.svh"

module kbks_dp #(
    parameter int SKETCH_CAPACITY = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kbks_pkg::t_in_word   i_in_word,
    input  logic [4:0]           i_kmer_size,
    input  logic [7:0]           i_sketch_size,
    input  kbks_pkg::t_dp_cmd    i_cmd,
    output kbks_pkg::t_dp_status o_status,
    output kbks_pkg::t_out_word  o_out_word
);
    import kbks_pkg::*;

    localparam int CW = $clog2(SKETCH_CAPACITY + 1);
    localparam int IW = $clog2(SKETCH_CAPACITY);

    logic [61:0] r_fwd, r_rev;
    logic [4:0]  r_run;
    logic [CW-1:0] r_count;
    logic [63:0] r_cell [SKETCH_CAPACITY];
    logic [SKETCH_CAPACITY-1:0] r_g;
    logic        r_dup;
    logic [63:0] r_h, r_key, r_rd_val;
    logic [4:0]  r_k;
    logic        r_fresh, r_rd_ok, r_ins;
    t_out_word   r_out;

    logic [2:0]  code;
    logic [4:0]  k_in;
    logic [63:0] m_in, m_k;
    logic [5:0]  shift1;
    logic [63:0] fwd_w, rev_w;
    logic [4:0]  run_inc;
    logic [63:0] canon;
    logic [63:0] t_mix, n_h;
    logic [CW-1:0] limit;
    logic [15:0] limit16;
    logic        has_room;
    logic [SKETCH_CAPACITY-1:0] n_g;
    logic        n_dup;
    logic        do_ins;
    logic        rd_in_range;
    logic [IW-1:0] rd_idx;

    assign code    = base_code(i_in_word.base_byte);
    assign k_in    = (i_kmer_size == 5'd0) ? 5'd1 : i_kmer_size;
    assign m_in    = (64'd1 << {k_in, 1'b0}) - 64'd1;
    assign m_k     = (64'd1 << {r_k, 1'b0}) - 64'd1;
    assign shift1  = {k_in - 5'd1, 1'b0};
    assign fwd_w   = ((64'(r_fwd) << 2) | 64'(code[1:0])) & m_in;
    assign rev_w   = ((64'(r_rev) >> 2) | (64'(2'b11 ^ code[1:0]) << shift1)) & MASK62;
    assign run_inc = (r_run == 5'd31) ? r_run : r_run + 5'd1;
    assign canon   = (fwd_w < rev_w) ? fwd_w : rev_w;

    assign limit16  = (16'(i_sketch_size) < 16'(SKETCH_CAPACITY)) ?
                      16'(i_sketch_size) : 16'(SKETCH_CAPACITY);
    assign limit    = limit16[CW-1:0];
    assign has_room = r_count < limit;

    assign rd_in_range = 16'(i_in_word.entry_index) < 16'(r_count);
    assign rd_idx      = IW'(i_in_word.entry_index);

    always_comb begin
        t_mix = '0;
        n_h   = r_h;
        case (i_cmd.hash_step)
            2'd0: begin
                t_mix = (~r_h + (r_h << 21)) & m_k;
                n_h   = t_mix ^ (t_mix >> 24);
            end
            2'd1: begin
                t_mix = (r_h + (r_h << 3) + (r_h << 8)) & m_k;
                n_h   = t_mix ^ (t_mix >> 14);
            end
            2'd2: begin
                t_mix = (r_h + (r_h << 2) + (r_h << 4)) & m_k;
                n_h   = t_mix ^ (t_mix >> 28);
            end
            2'd3: begin
                t_mix = (r_h + (r_h << 31)) & m_k;
                n_h   = t_mix;
            end
            default: n_h = r_h;
        endcase
    end

    always_comb begin
        n_dup = 1'b0;
        for (int i = 0; i < SKETCH_CAPACITY; i++) begin
            if (i < int'(r_count)) begin
                n_g[i] = r_cell[i] > r_key;
                n_dup  = n_dup | (r_cell[i] == r_key);
            end else begin
                n_g[i] = has_room;
            end
        end
    end

    assign do_ins = (|r_g) && !r_dup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd   <= '0;
            r_rev   <= '0;
            r_run   <= '0;
            r_count <= '0;
            r_fresh <= 1'b0;
            r_rd_ok <= 1'b0;
            r_ins   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_fresh <= 1'b0;
                r_rd_ok <= 1'b0;
                r_ins   <= 1'b0;
                case (i_in_word.action)
                    ACT_BASE: begin
                        if (!code[2]) begin
                            r_fwd <= fwd_w[61:0];
                            r_rev <= rev_w[61:0];
                            if (fwd_w != rev_w) begin
                                r_run   <= run_inc;
                                r_fresh <= run_inc >= k_in;
                            end
                        end else begin
                            r_run <= '0;
                        end
                    end
                    ACT_CLEAR: begin
                        r_fwd   <= '0;
                        r_rev   <= '0;
                        r_run   <= '0;
                        r_count <= '0;
                    end
                    ACT_READ: r_rd_ok <= rd_in_range;
                    default:  r_rd_ok <= 1'b0;
                endcase
            end
            if (i_cmd.upd_en && do_ins) begin
                r_ins <= 1'b1;
                if (has_room) begin
                    r_count <= r_count + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_h      <= canon;
            r_k      <= k_in;
            r_rd_val <= r_cell[rd_idx];
        end else if (i_cmd.hash_en) begin
            r_h <= n_h;
            if (i_cmd.hash_step == 2'd3) begin
                r_key <= {n_h[55:0], 3'b000, r_k};
            end
        end
        if (i_cmd.cmp_en) begin
            r_g   <= n_g;
            r_dup <= n_dup;
        end
        if (i_cmd.upd_en && do_ins) begin
            for (int i = 0; i < SKETCH_CAPACITY; i++) begin
                if (i > 0 && r_g[i] && r_g[(i > 0) ? i - 1 : 0]) begin
                    r_cell[i] <= r_cell[(i > 0) ? i - 1 : 0];
                end else if (r_g[i]) begin
                    r_cell[i] <= r_key;
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out.hash_value   <= r_fresh ? r_key : (r_rd_ok ? r_rd_val : 64'd0);
            r_out.hash_valid   <= r_fresh || r_rd_ok;
            r_out.inserted     <= r_ins;
            r_out.sketch_count <= 8'(r_count);
        end
    end

    assign o_status.fresh = r_fresh;
    assign o_out_word     = r_out;

    `KBKS_CHECK(a_count_bound, i_clk, i_rst_n, r_count <= CW'(SKETCH_CAPACITY))
    `KBKS_CHECK_IMPL(a_ins_nonempty, i_clk, i_rst_n, r_ins, r_count != '0)
    `KBKS_CHECK_NEXT(a_clear_empties, i_clk, i_rst_n,
        i_cmd.load && (i_in_word.action == ACT_CLEAR), r_count == '0)

endmodule

### rtl/core/kmer_bottom_k_sketch.sv
// ----------------------------------------------------------------------------
// kmer_bottom_k_sketch
// canonical k-mer minhash with a sorted bottom-k sketch of keys
// ----------------------------------------------------------------------------
// One word is taken at a time. A break, palindrome, short run, clear or read
// passes from acceptance through the decide state to a pending result; a base
// that yields a fresh key also passes through the four hash rounds in one mixing
// unit, then the compare and shift-insert over all sketch cells in parallel. A
// finished result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module kmer_bottom_k_sketch #(
    parameter int SKETCH_CAPACITY = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  kbks_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output kbks_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import kbks_pkg::*;

    logic [4:0] r_kmer_size;
    logic [7:0] r_sketch_size;
    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_size   <= KMER_SIZE_RESET;
            r_sketch_size <= SKETCH_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_KMER_SIZE:   r_kmer_size   <= i_cfg_data[4:0];
                REG_SKETCH_SIZE: r_sketch_size <= i_cfg_data;
                default:         r_kmer_size   <= r_kmer_size;
            endcase
        end
    end

    kbks_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    kbks_dp #(
        .SKETCH_CAPACITY (SKETCH_CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_word     (i_in_word),
        .i_kmer_size   (r_kmer_size),
        .i_sketch_size (r_sketch_size),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_word    (o_out_word)
    );

endmodule

### verif/kbks_checker.sv
// ----------------------------------------------------------------------------
// kbks_checker
// Watches the input, output and register channels of the k-mer sketch. It
// keeps its own copy of the k-mer registers, run length and sorted sketch,
// predicts one result per accepted input word and compares each output word
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module kbks_checker
    import kbks_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_key_count,
    output int        o_insert_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 128;

    logic [4:0]  kmer_len;
    logic [7:0]  keep_limit;
    logic [63:0] fwd_kmer;
    logic [63:0] rc_kmer;
    logic [4:0]  run_len;
    logic [63:0] min_keys [CAPACITY];
    int          key_total;
    t_out_word   expected_words [$];

    function automatic logic [63:0] mix_key(input logic [63:0] v, input logic [63:0] m);
        v = (~v + (v << 21)) & m;
        v = v ^ (v >> 24);
        v = (v + (v << 3) + (v << 8)) & m;
        v = v ^ (v >> 14);
        v = (v + (v << 2) + (v << 4)) & m;
        v = v ^ (v >> 28);
        v = (v + (v << 31)) & m;
        return v;
    endfunction

    function automatic bit holds_key(input logic [63:0] key);
        for (int i = 0; i < key_total; i++) begin
            if (min_keys[i] == key) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic place_key(input logic [63:0] key);
        int pos;
        pos = key_total;
        while (pos > 0 && min_keys[pos - 1] > key) begin
            min_keys[pos] = min_keys[pos - 1];
            pos--;
        end
        min_keys[pos] = key;
        key_total++;
    endtask

    task automatic offer_key(input logic [63:0] key, output bit taken);
        int lim;
        lim = (keep_limit > CAPACITY) ? CAPACITY : keep_limit;
        taken = 1'b0;
        if (key_total < lim) begin
            if (!holds_key(key)) begin
                place_key(key);
                taken = 1'b1;
            end
        end else if (key_total != 0 && min_keys[key_total - 1] > key && !holds_key(key)) begin
            key_total--;
            place_key(key);
            taken = 1'b1;
        end
    endtask

    task automatic wipe();
        fwd_kmer  = '0;
        rc_kmer   = '0;
        run_len   = '0;
        key_total = 0;
        for (int i = 0; i < CAPACITY; i++) begin
            min_keys[i] = '0;
        end
    endtask

    task automatic predict_word(input t_in_word w, output t_out_word r);
        logic [2:0]  code;
        logic [63:0] k;
        logic [63:0] m;
        logic [63:0] canon;
        bit          taken;
        r = '0;
        case (w.action)
            ACT_BASE: begin
                code = 3'd4;
                case (w.base_byte)
                    "A", "a": code = 3'd0;
                    "C", "c": code = 3'd1;
                    "G", "g": code = 3'd2;
                    "T", "t": code = 3'd3;
                    default:  code = 3'd4;
                endcase
                if (code < 4) begin
                    k = (kmer_len == 0) ? 64'd1 : 64'(kmer_len);
                    m = (64'd1 << (2 * k)) - 64'd1;
                    fwd_kmer = ((fwd_kmer << 2) | 64'(code)) & m;
                    rc_kmer = ((rc_kmer >> 2) | (64'(3 ^ code[1:0]) << (2 * (k - 1))))
                              & MASK62;
                    if (fwd_kmer != rc_kmer) begin
                        canon = (fwd_kmer < rc_kmer) ? fwd_kmer : rc_kmer;
                        if (run_len < 31) begin
                            run_len++;
                        end
                        if (64'(run_len) >= k) begin
                            r.hash_value = (mix_key(canon, m) << 8) | k;
                            r.hash_valid = 1'b1;
                            offer_key(r.hash_value, taken);
                            r.inserted = taken;
                        end
                    end
                end else begin
                    run_len = '0;
                end
            end
            ACT_CLEAR: wipe();
            ACT_READ: begin
                if (int'(w.entry_index) < key_total) begin
                    r.hash_value = min_keys[w.entry_index];
                    r.hash_valid = 1'b1;
                end
            end
            default: ;
        endcase
        r.sketch_count = 8'(key_total);
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            kmer_len   = KMER_SIZE_RESET;
            keep_limit = SKETCH_SIZE_RESET;
            wipe();
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_KMER_SIZE) begin
                    kmer_len = i_cfg_data[4:0];
                end else begin
                    keep_limit = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_word(i_in_word, want);
                expected_words.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_word;
                if (expected_words.size() == 0) begin
                    $error("unexpected output word %h", got);
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.hash_value !== want.hash_value) begin
                        $error("hash_value exp %h got %h", want.hash_value, got.hash_value);
                        o_fail_count++;
                    end
                    if (got.hash_valid !== want.hash_valid) begin
                        $error("hash_valid exp %b got %b", want.hash_valid, got.hash_valid);
                        o_fail_count++;
                    end
                    if (got.inserted !== want.inserted) begin
                        $error("inserted exp %b got %b", want.inserted, got.inserted);
                        o_fail_count++;
                    end
                    if (got.sketch_count !== want.sketch_count) begin
                        $error("sketch_count exp %0d got %0d", want.sketch_count,
                               got.sketch_count);
                        o_fail_count++;
                    end
                    if (want.hash_valid && want.hash_value[7:0] != 8'd0 && got.inserted) begin
                        o_insert_count++;
                    end
                    if (want.hash_valid) begin
                        o_key_count++;
                    end
                end
            end
        end
        o_pending = expected_words.size();
    end

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_key_count    = 0;
        o_insert_count = 0;
    end

endmodule

### verif/tb_kmer_bottom_k_sketch.sv
// ----------------------------------------------------------------------------
// tb_kmer_bottom_k_sketch
// Drives base, clear, read and unused-action words into the k-mer sketch through a
// series of k-mer and sketch sizes, with random idle cycles on both sides and
// one long output hold-off; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_kmer_bottom_k_sketch;
    import kbks_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_IDLE = 2'd3;
    localparam int STALL_LIMIT = 5000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_word   i_in_word = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_word;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index = 1'b0;
    logic [7:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int key_count;
    int insert_count;
    int words_sent = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    string letters = "ACGTacgt";
    string first_seq = "ACGTacgtNAGCT";
    string pal_seq = "ATATGCGCAAGG";

    kmer_bottom_k_sketch dut (.*);

    kbks_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_word      (i_in_word),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_word     (o_out_word),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_key_count    (key_count),
        .o_insert_count (insert_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_req <= 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < 9);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [1:0] act, input logic [7:0] b,
                             input logic [6:0] idx);
        t_in_word w;
        bit       taken;
        w.action      = act;
        w.base_byte   = b;
        w.entry_index = idx;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end
        words_sent++;
        if (!calm && $urandom_range(0, 99) < 9) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_base(input byte unsigned b);
        send_word(ACT_BASE, b, 7'($urandom));
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        bit taken;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic random_words(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 199);
            if (pick < 170) begin
                if ($urandom_range(0, 99) < 88) begin
                    send_base(letters[$urandom_range(0, 7)]);
                end else begin
                    send_base(8'($urandom));
                end
            end else if (pick < 192) begin
                send_word(ACT_READ, 8'($urandom),
                          ($urandom_range(0, 1) != 0) ? 7'($urandom) : 7'($urandom_range(0, 15)));
            end else if (pick < 196) begin
                send_word(ACT_CLEAR, 8'($urandom), 7'($urandom));
            end else begin
                send_word(ACT_IDLE, 8'($urandom), 7'($urandom));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default sizes: every letter, breaks, reads at the edges, clear
        for (int i = 0; i < first_seq.len(); i++) begin
            send_base(first_seq[i]);
        end
        send_base(8'h00);
        send_base(8'hFF);
        send_word(ACT_READ, 8'h00, 7'd0);
        send_word(ACT_READ, 8'hFF, 7'd127);
        send_word(ACT_IDLE, 8'hA5, 7'h55);
        send_word(ACT_CLEAR, 8'h5A, 7'h2A);
        random_words(60);
        drain();

        // k = 2 with a one-entry sketch, palindromes, no idling
        calm = 1'b1;
        write_reg(REG_KMER_SIZE, 8'd2);
        write_reg(REG_SKETCH_SIZE, 8'd1);
        for (int i = 0; i < pal_seq.len(); i++) begin
            send_base(pal_seq[i]);
        end
        send_word(ACT_READ, 8'h00, 7'd0);
        send_word(ACT_READ, 8'h00, 7'd1);
        random_words(100);
        drain();
        calm = 1'b0;

        write_reg(REG_KMER_SIZE, 8'hE3);
        write_reg(REG_SKETCH_SIZE, 8'hFF);
        random_words(110);
        drain();

        // longest k-mer, full sketch, long output hold-off
        write_reg(REG_KMER_SIZE, 8'd31);
        write_reg(REG_SKETCH_SIZE, 8'd128);
        hold_req = 1'b1;
        random_words(130);
        drain();

        write_reg(REG_KMER_SIZE, 8'd0);
        write_reg(REG_SKETCH_SIZE, 8'd0);
        random_words(90);
        drain();

        write_reg(REG_KMER_SIZE, 8'd4);
        write_reg(REG_SKETCH_SIZE, 8'd12);
        random_words(110);
        drain();

        // limit lowered below the current count
        write_reg(REG_SKETCH_SIZE, 8'd3);
        write_reg(REG_KMER_SIZE, 8'd5);
        random_words(110);
        drain();

        $display("sent %0d words over seven size settings; %0d keys and reads checked,",
                 words_sent, key_count);
        $display("%0d sketch inserts, one long output hold-off, random idling on both sides",
                 insert_count);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
